// ===== design/assert_macros.svh =====
// Shared assertion macros; clk and rst_n must be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled in reset.
`define RMAST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rmast assertion failed");

// Same-cycle implication.
`define RMAST_IMPLY(label, ante, cons) \
    `RMAST_ASSERT(label, (ante) |-> (cons))

`endif

// ===== design/rmast_pkg.sv =====
package rmast_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int POS_WIDTH_DEF = 32;
    localparam int OFFSET_W      = 32;
    localparam int MIN_W         = 64;
    localparam int SUM_W         = MIN_W + 2;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_PUSH    = 2'd1,
        OP_REPLACE = 2'd2
    } op_t;

endpackage

// ===== design/rmast_cell.sv =====
module rmast_cell
    import rmast_pkg::*;
#(
    parameter int W         = POS_WIDTH_DEF,
    parameter bit FIRST     = 1'b0,
    parameter bit MAX_FIRST = 1'b1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  op_t          op,
    input  logic [W-1:0] v,
    input  logic [W-1:0] prev_val,
    input  logic         prev_valid,
    input  logic         prev_beats,
    input  logic [W-1:0] next_val,
    input  logic         next_beats,
    output logic [W-1:0] val,
    output logic         valid,
    output logic         beats
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;
    logic         valid_reg;
    logic         valid_next;

    // cell holds an entry that stays ahead of v in chain order
    assign beats = valid_reg && (MAX_FIRST ? ($signed(val_reg) > $signed(v))
                                           : ($signed(val_reg) < $signed(v)));

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        case (op)
            OP_PUSH:
            begin
                valid_next = valid_reg | prev_valid | FIRST;
                if (beats)
                begin
                    val_next = val_reg;
                end
                else if (FIRST || prev_beats)
                begin
                    val_next = v;
                end
                else
                begin
                    val_next = prev_val;
                end
            end
            OP_REPLACE:
            begin
                // head removed, v sorted into the rest
                if (next_beats)
                begin
                    val_next = next_val;
                end
                else if (FIRST || beats)
                begin
                    val_next = v;
                end
                else
                begin
                    val_next = val_reg;
                end
            end
            default:
            begin
                val_next   = val_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// ===== design/rmast_chain.sv =====
module rmast_chain
    import rmast_pkg::*;
#(
    parameter int W         = POS_WIDTH_DEF,
    parameter int DEPTH     = CAPACITY_DEF / 2,
    parameter bit MAX_FIRST = 1'b1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  op_t          op,
    input  logic [W-1:0] v,
    output logic [W-1:0] top
);

`include "assert_macros.svh"

    logic [W-1:0] val   [DEPTH];
    logic         valid [DEPTH];
    logic         beats [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [W-1:0] prev_val;
            logic         prev_valid;
            logic         prev_beats;
            logic [W-1:0] next_val;
            logic         next_beats;

            if (i == 0)
            begin : g_head
                assign prev_val   = '0;
                assign prev_valid = 1'b0;
                assign prev_beats = 1'b0;
            end
            else
            begin : g_body
                assign prev_val   = val[i-1];
                assign prev_valid = valid[i-1];
                assign prev_beats = beats[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_val   = '0;
                assign next_beats = 1'b0;
            end
            else
            begin : g_link
                assign next_val   = val[i+1];
                assign next_beats = beats[i+1];
            end

            rmast_cell #(
                .W         (W),
                .FIRST     (i == 0),
                .MAX_FIRST (MAX_FIRST)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .v          (v),
                .prev_val   (prev_val),
                .prev_valid (prev_valid),
                .prev_beats (prev_beats),
                .next_val   (next_val),
                .next_beats (next_beats),
                .val        (val[i]),
                .valid      (valid[i]),
                .beats      (beats[i])
            );

            if (i > 0)
            begin : g_chk
                `RMAST_IMPLY(a_valid_packed, valid[i], valid[i-1])
            end
        end
    endgenerate

    assign top = val[0];

endmodule

// ===== design/running_median_abs_sum_tracker.sv =====
// Queries (cmd = 1) are answered in the cycle after the transfer: valid is high for a single
// cycle and the receiver cannot stall it; busy never rises for a query. For an add (cmd = 0),
// in the transfer cycle the term is compared with the heads of the two sorted cell chains,
// and in the next cycle (busy high) every cell of both chains shifts or inserts in parallel
// and the minimum is updated with one saturating three-way add, with no new transfer taken.
// So the rate is one query per cycle while busy is low. Stores need no clearing after reset;
// an add while CAPACITY terms are held is dropped; later answers show lost_flag until reset.
module running_median_abs_sum_tracker
    import rmast_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic signed [POS_WIDTH-1:0] position,
    input  logic signed [OFFSET_W-1:0]  offset,
    output logic                        valid,
    output logic signed [POS_WIDTH-1:0] best_position,
    output logic signed [MIN_W-1:0]     min_value,
    output logic                        empty_flag,
    output logic                        lost_flag
);

`include "assert_macros.svh"

    localparam int LO_DEPTH = (CAPACITY + 1) / 2;
    localparam int UP_DEPTH = CAPACITY / 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PW       = POS_WIDTH;

    logic [CNT_W-1:0]    total_count_reg, total_count_next;
    logic                apply_reg, apply_next;
    logic                lost_reg, lost_next;
    logic [MIN_W-1:0]    minimum_reg, minimum_next;

    op_t                 lo_op_reg, lo_op_next;
    op_t                 up_op_reg, up_op_next;
    logic [PW-1:0]       lo_v_reg, lo_v_next;
    logic [PW-1:0]       up_v_reg, up_v_next;
    logic [PW-1:0]       d_reg, d_next;
    logic [OFFSET_W-1:0] b_reg, b_next;
    logic                first_reg, first_next;

    logic                valid_reg, valid_next;
    logic [PW-1:0]       best_reg, best_next;
    logic [MIN_W-1:0]    min_out_reg, min_out_next;
    logic                empty_reg, empty_next;
    logic                lost_out_reg, lost_out_next;

    logic [PW-1:0]       lo_top, up_top;
    logic signed [PW:0]  lo_m_a, a_m_lo, a_m_up;
    logic                accept, is_empty, is_full;
    logic [SUM_W-1:0]    sum;
    logic [MIN_W-1:0]    sat_sum;

    assign accept   = start && !apply_reg;
    assign busy     = apply_reg;
    assign is_empty = (total_count_reg == '0);
    assign is_full  = (total_count_reg >= CNT_W'(CAPACITY));

    rmast_chain #(
        .W         (PW),
        .DEPTH     (LO_DEPTH),
        .MAX_FIRST (1'b1)
    ) u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (apply_reg ? lo_op_reg : OP_NONE),
        .v     (lo_v_reg),
        .top   (lo_top)
    );

    rmast_chain #(
        .W         (PW),
        .DEPTH     (UP_DEPTH),
        .MAX_FIRST (1'b0)
    ) u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (apply_reg ? up_op_reg : OP_NONE),
        .v     (up_v_reg),
        .top   (up_top)
    );

    assign lo_m_a = $signed({lo_top[PW-1], lo_top}) - $signed({position[PW-1], position});
    assign a_m_lo = $signed({position[PW-1], position}) - $signed({lo_top[PW-1], lo_top});
    assign a_m_up = $signed({position[PW-1], position}) - $signed({up_top[PW-1], up_top});

    // decision made in the transfer cycle
    always_comb
    begin
        lo_op_next = OP_NONE;
        up_op_next = OP_NONE;
        lo_v_next  = position;
        up_v_next  = position;
        d_next     = '0;
        b_next     = offset;
        first_next = is_empty;
        if (is_empty)
        begin
            lo_op_next = OP_PUSH;
        end
        else if (total_count_reg[0])
        begin
            d_next = lo_m_a[PW] ? a_m_lo[PW-1:0] : lo_m_a[PW-1:0];
            if (lo_m_a[PW])
            begin
                up_op_next = OP_PUSH;
            end
            else
            begin
                up_op_next = OP_PUSH;
                up_v_next  = lo_top;
                lo_op_next = OP_REPLACE;
            end
        end
        else
        begin
            if (a_m_up[PW])
            begin
                lo_op_next = OP_PUSH;
                d_next     = lo_m_a[PW] ? '0 : lo_m_a[PW-1:0];
            end
            else
            begin
                lo_op_next = OP_PUSH;
                lo_v_next  = up_top;
                up_op_next = OP_REPLACE;
                d_next     = a_m_up[PW-1:0];
            end
        end
    end

    assign sum = {{(SUM_W-MIN_W){minimum_reg[MIN_W-1]}}, minimum_reg}
               + {{(SUM_W-PW){1'b0}}, d_reg}
               + {{(SUM_W-OFFSET_W){b_reg[OFFSET_W-1]}}, b_reg};

    always_comb
    begin
        if (sum[SUM_W-1:MIN_W-1] == '0 || sum[SUM_W-1:MIN_W-1] == '1)
        begin
            sat_sum = sum[MIN_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_sum = {1'b1, {(MIN_W-1){1'b0}}};
        end
        else
        begin
            sat_sum = {1'b0, {(MIN_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        apply_next       = 1'b0;
        lost_next        = lost_reg;
        total_count_next = total_count_reg;
        minimum_next     = minimum_reg;
        valid_next       = 1'b0;
        best_next        = best_reg;
        min_out_next     = min_out_reg;
        empty_next       = empty_reg;
        lost_out_next    = lost_out_reg;

        if (apply_reg)
        begin
            total_count_next = total_count_reg + CNT_W'(1);
            minimum_next     = first_reg ? {{(MIN_W-OFFSET_W){b_reg[OFFSET_W-1]}}, b_reg}
                                         : sat_sum;
        end
        else if (accept)
        begin
            if (cmd)
            begin
                valid_next    = 1'b1;
                best_next     = is_empty ? '0 : lo_top;
                min_out_next  = is_empty ? '0 : minimum_reg;
                empty_next    = is_empty;
                lost_out_next = lost_reg;
            end
            else if (is_full)
            begin
                lost_next = 1'b1;
            end
            else
            begin
                apply_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apply_reg       <= 1'b0;
            lost_reg        <= 1'b0;
            total_count_reg <= '0;
            minimum_reg     <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            apply_reg       <= apply_next;
            lost_reg        <= lost_next;
            total_count_reg <= total_count_next;
            minimum_reg     <= minimum_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cmd)
        begin
            lo_op_reg <= lo_op_next;
            up_op_reg <= up_op_next;
            lo_v_reg  <= lo_v_next;
            up_v_reg  <= up_v_next;
            d_reg     <= d_next;
            b_reg     <= b_next;
            first_reg <= first_next;
        end
        best_reg     <= best_next;
        min_out_reg  <= min_out_next;
        empty_reg    <= empty_next;
        lost_out_reg <= lost_out_next;
    end

    assign valid         = valid_reg;
    assign best_position = best_reg;
    assign min_value     = min_out_reg;
    assign empty_flag    = empty_reg;
    assign lost_flag     = lost_out_reg;

    `RMAST_ASSERT(a_busy_single, busy |=> !busy)
    `RMAST_ASSERT(a_valid_from_query, valid |-> $past(start && !busy && cmd))
    `RMAST_ASSERT(a_count_bound, total_count_reg <= CNT_W'(CAPACITY))
    `RMAST_ASSERT(a_lost_sticky, lost_reg |=> lost_reg)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rmast_pkg::*;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   WATCHDOG_LIMIT = 1000;
    localparam longint MINIMUM_CEIL  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint MINIMUM_FLOOR = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [POS_WIDTH_DEF-1:0] best_position;
        logic signed [MIN_W-1:0]         min_value;
        logic                            empty_flag;
        logic                            lost_flag;
    } answer_t;

    class median_sum_predictor;
        longint  lower_q[$];
        longint  upper_q[$];
        longint  median;
        longint  minimum;
        bit      lost;
        answer_t pending_answers[$];
        int      failures;

        // lower kept ascending, max at back
        function void insert_lower(longint v);
            int i;
            i = lower_q.size();
            while (i > 0 && lower_q[i-1] > v)
                i--;
            lower_q.insert(i, v);
        endfunction

        // upper kept descending, min at back
        function void insert_upper(longint v);
            int i;
            i = upper_q.size();
            while (i > 0 && upper_q[i-1] < v)
                i--;
            upper_q.insert(i, v);
        endfunction

        function longint lower_top();
            return (lower_q.size() != 0) ? lower_q[$] : 0;
        endfunction

        function longint upper_top();
            return (upper_q.size() != 0) ? upper_q[$] : 0;
        endfunction

        function longint distance(longint x, longint y);
            longint d;
            d = x - y;
            return (d < 0) ? -d : d;
        endfunction

        function void add_to_minimum(longint inc);
            logic signed [MIN_W+1:0] sum;
            sum = minimum + inc;
            if (sum > MINIMUM_CEIL)
                minimum = MINIMUM_CEIL;
            else if (sum < MINIMUM_FLOOR)
                minimum = MINIMUM_FLOOR;
            else
                minimum = longint'(sum);
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        function void record_transfer(logic c, logic signed [POS_WIDTH_DEF-1:0] p,
                                      logic signed [OFFSET_W-1:0] o);
            longint  a;
            longint  b;
            longint  old;
            int      held;
            answer_t ans;
            held = lower_q.size() + upper_q.size();
            if (c == CMD_QUERY)
            begin
                ans.empty_flag    = (held == 0);
                ans.best_position = (held == 0) ? '0 : POS_WIDTH_DEF'(median);
                ans.min_value     = (held == 0) ? '0 : minimum;
                ans.lost_flag     = lost;
                pending_answers.insert(pending_answers.size(), ans);
                return;
            end
            a = p;
            b = o;
            if (held >= CAPACITY_DEF)
            begin
                lost = 1'b1;
                return;
            end
            if (held == 0)
            begin
                insert_lower(a);
                median  = a;
                minimum = b;
            end
            else if (held % 2 == 1)
            begin
                if (lower_top() < a)
                begin
                    insert_upper(a);
                    add_to_minimum(distance(median, a) + b);
                end
                else
                begin
                    old = lower_top();
                    insert_upper(old);
                    void'(lower_q.pop_back());
                    insert_lower(a);
                    median = lower_top();
                    add_to_minimum(distance(old, a) + b);
                end
            end
            else
            begin
                if (a < upper_top())
                begin
                    insert_lower(a);
                    median = lower_top();
                end
                else
                begin
                    median = upper_top();
                    insert_lower(median);
                    void'(upper_q.pop_back());
                    insert_upper(a);
                end
                add_to_minimum(distance(median, a) + b);
            end
        endfunction

        function void check_answer(logic signed [POS_WIDTH_DEF-1:0] best,
                                   logic signed [MIN_W-1:0] minv, logic empty, logic lostf);
            answer_t exp;
            if (pending_answers.size() == 0)
            begin
                $error("result strobe with no query outstanding");
                failures++;
                return;
            end
            exp = pending_answers.pop_front();
            if (best !== exp.best_position)
            begin
                $error("best_position: expected %0d, got %0d", exp.best_position, best);
                failures++;
            end
            if (minv !== exp.min_value)
            begin
                $error("min_value: expected %0d, got %0d", exp.min_value, minv);
                failures++;
            end
            if (empty !== exp.empty_flag)
            begin
                $error("empty_flag: expected %0b, got %0b", exp.empty_flag, empty);
                failures++;
            end
            if (lostf !== exp.lost_flag)
            begin
                $error("lost_flag: expected %0b, got %0b", exp.lost_flag, lostf);
                failures++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            cmd;
    logic signed [POS_WIDTH_DEF-1:0] position;
    logic signed [OFFSET_W-1:0]      offset;
    logic                            valid;
    logic signed [POS_WIDTH_DEF-1:0] best_position;
    logic signed [MIN_W-1:0]         min_value;
    logic                            empty_flag;
    logic                            lost_flag;

    median_sum_predictor sb;
    int quiet_cycles = 0;
    int adds_sent = 0;
    bit idle_enabled = 1'b1;

    running_median_abs_sum_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .position     (position),
        .offset       (offset),
        .valid        (valid),
        .best_position(best_position),
        .min_value    (min_value),
        .empty_flag   (empty_flag),
        .lost_flag    (lost_flag)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
                sb.check_answer(best_position, min_value, empty_flag, lost_flag);
            if (start && !busy)
                sb.record_transfer(cmd, position, offset);
            if (valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("running_median_abs_sum_tracker regression: fail");
                $finish;
            end
        end
    end

    // mixes extremes, tight clusters (ties) and full-range values
    function automatic logic signed [OFFSET_W-1:0] random_operand();
        case ($urandom_range(7)) inside
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed($urandom_range(40)) - 20;
            3, 4: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic c, input logic signed [POS_WIDTH_DEF-1:0] p,
                             input logic signed [OFFSET_W-1:0] o);
        start    <= 1'b1;
        cmd      <= c;
        position <= p;
        offset   <= o;
        do
            @(posedge clk);
        while (busy);
        if (c == CMD_ADD)
            adds_sent++;
        if (idle_enabled && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding query has been answered
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    initial
    begin
        sb       = new;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = CMD_ADD;
        position = '0;
        offset   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_QUERY, -1, -1);
        send_item(CMD_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_ADD, 32'sh8000_0000, 32'sh8000_0000);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_ADD, 0, -1);
        send_item(CMD_ADD, 0, 0);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_ADD, 5, 32'sh8000_0000);
        send_item(CMD_ADD, -3, 7);
        send_item(CMD_ADD, -100, -5);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_ADD, -1, 0);
        send_item(CMD_ADD, -1, 0);
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_QUERY, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_item(CMD_ADD, 32'sh7FFF_FFFF, 1);
        send_item(CMD_QUERY, 0, 0);
        drain();

        for (int i = 0; i < 1200; i++)
        begin
            idle_enabled = !(i >= 400 && i < 700);
            if (i == 900)
                drain();
            if ($urandom_range(99) < 60)
                send_item(CMD_ADD, random_operand(), random_operand());
            else
                send_item(CMD_QUERY, $urandom, $urandom);
        end

        // fill to capacity, then push a few adds that must be dropped
        while (adds_sent < CAPACITY_DEF + 8)
        begin
            if ($urandom_range(99) < 20)
                send_item(CMD_QUERY, $urandom, $urandom);
            else
                send_item(CMD_ADD, random_operand(), random_operand());
        end
        send_item(CMD_QUERY, 0, 0);

        drain();
        repeat (4) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("running_median_abs_sum_tracker regression: pass");
        else
            $display("running_median_abs_sum_tracker regression: fail");
        $finish;
    end
endmodule
